// ===== src/sairs_pkg.sv =====
// ----------------------------------------------------------------------------
// sairs_pkg: shared definitions for the shift array list
// Default sizes, request and status codes, and the control group that the
// top level broadcasts to every cell.
// ----------------------------------------------------------------------------
package sairs_pkg;

   localparam int SAIRS_DEPTH      = 16;
   localparam int SAIRS_DATA_WIDTH = 32;
   localparam int CSR_W            = 5;
   localparam logic [CSR_W-1:0] CSR_CAPACITY_RESET = 5'd16;

   typedef enum logic [1:0] {
      MODE_SEARCH = 2'd0,
      MODE_INSERT = 2'd1,
      MODE_REMOVE = 2'd2,
      MODE_NOP    = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_RANGE     = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

   typedef struct packed {
      logic capture;
      logic shift_up;
      logic shift_down;
   } cell_ctl_type;

endpackage

// ===== src/sairs_cell.sv =====
// ----------------------------------------------------------------------------
// sairs_cell: one position of the shift array
// Holds one entry, takes its neighbor's entry or the key on an insert or a remove, and
// registers whether it matches the search key.
// ----------------------------------------------------------------------------
module sairs_cell #(
   parameter int DATA_WIDTH = 32,
   parameter int CNT_W      = 5,
   parameter int IDX        = 0
) (
   input  logic                      clock,
   input  sairs_pkg::cell_ctl_type   ctl,
   input  logic [3:0]                pos,
   input  logic [CNT_W-1:0]          count,
   input  logic [DATA_WIDTH-1:0]     key,
   input  logic [DATA_WIDTH-1:0]     left_data,
   input  logic [DATA_WIDTH-1:0]     right_data,
   output logic [DATA_WIDTH-1:0]     entry,
   output logic                      hit
);
   import sairs_pkg::*;

   logic [DATA_WIDTH-1:0] entry_ff, entry_in;
   logic                  hit_ff, hit_in;

   always_comb begin
      entry_in = entry_ff;
      if (ctl.shift_up) begin
         if (IDX > int'(pos)) begin
            entry_in = left_data;
         end else if (IDX == int'(pos)) begin
            entry_in = key;
         end
      end else if (ctl.shift_down) begin
         if (IDX >= int'(pos)) begin
            entry_in = right_data;
         end
      end
   end

   assign hit_in = ctl.capture ? ((CNT_W'(IDX) < count) && (entry_ff == key)) : hit_ff;

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      hit_ff   <= hit_in;
   end

   assign entry = entry_ff;
   assign hit   = hit_ff;

endmodule

// ===== src/sairs_first_hit.sv =====
// ----------------------------------------------------------------------------
// sairs_first_hit: lowest set position of the match vector
// A binary tree of pairwise selects, one level per address bit.
// ----------------------------------------------------------------------------
module sairs_first_hit #(
   parameter int DEPTH = 16,
   parameter int IW    = 4
) (
   input  logic [DEPTH-1:0] hits,
   output logic             any,
   output logic [IW-1:0]    index
);
   import sairs_pkg::*;

   localparam int P = 1 << IW;

   logic          node_hit [2*P-1];
   logic [IW-1:0] node_idx [2*P-1];

   genvar g;
   generate
      for (g = 0; g < P; g++) begin : g_leaf
         if (g < DEPTH) begin : g_real
            assign node_hit[P-1+g] = hits[g];
         end else begin : g_pad
            assign node_hit[P-1+g] = 1'b0;
         end
         assign node_idx[P-1+g] = IW'(g);
      end
      for (g = 0; g < P-1; g++) begin : g_node
         assign node_hit[g] = node_hit[2*g+1] | node_hit[2*g+2];
         assign node_idx[g] = node_hit[2*g+1] ? node_idx[2*g+1] : node_idx[2*g+2];
      end
   endgenerate

   assign any   = node_hit[0];
   assign index = node_idx[0];

endmodule

// ===== src/shift_array_insert_remove_search.sv =====
// ----------------------------------------------------------------------------
// shift_array_insert_remove_search: packed list with insert, remove, search
//
//   channel  dir  ports                 transfer carries
//   req      in   req_tvalid/tready     mode, index, value
//   rsp      out  rsp_tvalid/tready     status, found_index, count
//   csr      in   csr_wr_en             capacity
//
// A request is registered in the cells, which register their match flags,
// and in the encode stage, then in the output register behind the priority
// tree; a stall on the rsp channel can hold it between them. One request per
// cycle is sustained while rsp_tready stays high. Reset clears the count and
// sets capacity to 16; entries are not cleared. A stalled result is held in
// the output register while one more request waits in the encode stage.
// ----------------------------------------------------------------------------
module shift_array_insert_remove_search #(
   parameter int DEPTH      = sairs_pkg::SAIRS_DEPTH,
   parameter int DATA_WIDTH = sairs_pkg::SAIRS_DATA_WIDTH
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [39:0]             req_tdata,   // mode[1:0], index[5:2], value[37:6]
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [15:0]             rsp_tdata,   // status[1:0], found_index[5:2], count[10:6]
   input  logic                    csr_wr_en,
   input  logic [sairs_pkg::CSR_W-1:0] csr_wr_data
);
   import sairs_pkg::*;

   localparam int IW    = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int CMP_W = (CNT_W > CSR_W) ? CNT_W : CSR_W;

   logic                    accept, advance;
   mode_type                mode;
   logic [3:0]              pos;
   logic signed [31:0]      value_s;
   logic [DATA_WIDTH-1:0]   key;

   logic [CSR_W-1:0]        capacity_ff, capacity_in;
   logic [CNT_W-1:0]        count_ff, count_in;

   logic                    op_valid_ff, op_valid_in;
   logic                    op_search_ff, op_search_in;
   status_type              op_status_ff, op_status_in;
   logic [CNT_W-1:0]        op_count_ff, op_count_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   status_type              rsp_status_ff, rsp_status_in;
   logic [IW-1:0]           rsp_found_ff, rsp_found_in;
   logic [CNT_W-1:0]        rsp_count_ff, rsp_count_in;

   logic [CMP_W-1:0]        cnt_x, cap_x, pos_x, dep_x;
   logic                    is_full, ins_range, rem_range;
   logic                    do_insert, do_remove;
   status_type              req_status;
   cell_ctl_type            ctl;

   logic [DATA_WIDTH-1:0]   entry [DEPTH];
   logic [DEPTH-1:0]        hits;
   logic                    hit_any;
   logic [IW-1:0]           hit_index;

   assign mode    = mode_type'(req_tdata[1:0]);
   assign pos     = req_tdata[5:2];
   assign value_s = signed'(req_tdata[37:6]);
   assign key     = DATA_WIDTH'(value_s);

   assign advance    = op_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !op_valid_ff || advance;
   assign accept     = req_tvalid && req_tready;

   assign cnt_x = CMP_W'(count_ff);
   assign cap_x = CMP_W'(capacity_ff);
   assign pos_x = CMP_W'(pos);
   assign dep_x = CMP_W'(DEPTH);

   assign is_full   = (cnt_x >= cap_x) || (cnt_x >= dep_x);
   assign ins_range = (pos_x > cnt_x) || (pos_x >= dep_x);
   assign rem_range = (pos_x >= cnt_x) || (pos_x >= dep_x);

   always_comb begin
      do_insert  = 1'b0;
      do_remove  = 1'b0;
      req_status = ST_OK;
      unique case (mode)
         MODE_SEARCH: req_status = ST_OK;
         MODE_INSERT: begin
            if (is_full) begin
               req_status = ST_FULL;
            end else if (ins_range) begin
               req_status = ST_RANGE;
            end else begin
               do_insert = 1'b1;
            end
         end
         MODE_REMOVE: begin
            if (rem_range) begin
               req_status = ST_RANGE;
            end else begin
               do_remove = 1'b1;
            end
         end
         MODE_NOP: req_status = ST_OK;
         default: req_status = ST_OK;
      endcase
   end

   assign ctl.capture    = accept;
   assign ctl.shift_up   = accept && do_insert;
   assign ctl.shift_down = accept && do_remove;

   always_comb begin
      count_in = count_ff;
      if (ctl.shift_up) begin
         count_in = count_ff + CNT_W'(1);
      end else if (ctl.shift_down) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   assign capacity_in = csr_wr_en ? csr_wr_data : capacity_ff;

   assign op_valid_in  = accept ? 1'b1 : (advance ? 1'b0 : op_valid_ff);
   assign op_search_in = accept ? (mode == MODE_SEARCH) : op_search_ff;
   assign op_status_in = accept ? req_status : op_status_ff;
   assign op_count_in  = accept ? count_in : op_count_ff;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_count_in  = rsp_count_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
         rsp_count_in = op_count_ff;
         rsp_found_in = '0;
         if (op_search_ff) begin
            rsp_status_in = hit_any ? ST_OK : ST_NOT_FOUND;
            if (hit_any) begin
               rsp_found_in = hit_index;
            end
         end else begin
            rsp_status_in = op_status_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff  <= CSR_CAPACITY_RESET;
         count_ff     <= '0;
         op_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         capacity_ff  <= capacity_in;
         count_ff     <= count_in;
         op_valid_ff  <= op_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_search_ff  <= op_search_in;
      op_status_ff  <= op_status_in;
      op_count_ff   <= op_count_in;
      rsp_status_ff <= rsp_status_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_count_ff  <= rsp_count_in;
   end

   genvar i;
   generate
      for (i = 0; i < DEPTH; i++) begin : g_cell
         logic [DATA_WIDTH-1:0] left_data, right_data;
         if (i == 0) begin : g_first
            assign left_data = key;
         end else begin : g_left
            assign left_data = entry[i-1];
         end
         if (i == DEPTH - 1) begin : g_last
            assign right_data = key;
         end else begin : g_right
            assign right_data = entry[i+1];
         end
         sairs_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .CNT_W      (CNT_W),
            .IDX        (i)
         ) u_cell (
            .clock      (clock),
            .ctl        (ctl),
            .pos        (pos),
            .count      (count_ff),
            .key        (key),
            .left_data  (left_data),
            .right_data (right_data),
            .entry      (entry[i]),
            .hit        (hits[i])
         );
      end
   endgenerate

   sairs_first_hit #(
      .DEPTH (DEPTH),
      .IW    (IW)
   ) u_first_hit (
      .hits  (hits),
      .any   (hit_any),
      .index (hit_index)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, 5'(rsp_count_ff), 4'(rsp_found_ff), rsp_status_ff};

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      CMP_W'(count_ff) <= dep_x)
      else $error("count exceeds depth");

   a_refused_holds: assert property (@(posedge clock) disable iff (reset)
      accept && !do_insert && !do_remove |=> $stable(count_ff))
      else $error("refused request changed the count");

   a_advance_fills: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("result lost between stages");

   a_found_below_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_found_ff != '0) |-> CNT_W'(rsp_found_ff) < rsp_count_ff)
      else $error("found index at or past count");

endmodule
